// File: hw/rtl/svie_pkg.sv
package svie_pkg;

	localparam int MEM_WORDS_DEF = 1024;
	localparam int NUM_REGS      = 4;
	localparam int RIDX_W        = $clog2(NUM_REGS);
	localparam int PC_W          = 10;
	localparam int WORD_W        = 32;
	localparam int S_DATA_W      = 160;
	localparam int M_DATA_W      = 64;

	localparam logic CMD_EXEC    = 1'b0;
	localparam logic CMD_PRELOAD = 1'b1;

	localparam logic [1:0] FLAG_POS  = 2'd0;
	localparam logic [1:0] FLAG_NEG  = 2'd1;
	localparam logic [1:0] FLAG_ZERO = 2'd2;

	typedef enum logic [4:0] {
		OP_HALT, OP_LOAD, OP_STORE, OP_READ, OP_WRITE, OP_COPY, OP_PUSH, OP_POP,
		OP_JUMP, OP_JZ, OP_JNZ, OP_JN, OP_JNN, OP_CALL, OP_RET, OP_AND,
		OP_OR, OP_NOT, OP_XOR, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
		OP_CMP, OP_TST
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_DIV, ST_EXEC, ST_DONE
	} state_t;

	typedef struct packed {
		logic latch;
		logic mem_rd;
		logic div_start;
		logic commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_div;
		logic div_done;
		logic out_free;
	} stat_t;

	function automatic logic [1:0] flags_of(input logic [WORD_W-1:0] v);
		logic [1:0] f;
		if (v == '0) f = FLAG_ZERO;
		else if (v[WORD_W-1]) f = FLAG_NEG;
		else f = FLAG_POS;
		return f;
	endfunction

endpackage

// File: hw/rtl/svie_div.sv
module svie_div
	import svie_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic              done,
	output logic [WORD_W-1:0] quot,
	output logic [WORD_W-1:0] rem
);

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q, done_q, nq_q, nr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] r_q, q_q, d_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W-1:0] shifted;

	assign shifted = {r_q[WORD_W-2:0], q_q[WORD_W-1]};
	assign trial   = {r_q, q_q[WORD_W-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend[WORD_W-1] ? -dividend : dividend;
			d_q  <= divisor[WORD_W-1] ? -divisor : divisor;
			r_q  <= '0;
			nq_q <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
			nr_q <= dividend[WORD_W-1];
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				r_q <= trial[WORD_W-1:0];
				q_q <= {q_q[WORD_W-2:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q ? -q_q : q_q;
	assign rem  = nr_q ? -r_q : r_q;

endmodule

// File: hw/rtl/svie_ctrl.sv
module svie_ctrl
	import svie_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  stat_t stat,
	output logic  req_ready,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (req_valid) state_d = ST_READ;
			ST_READ: state_d = stat.is_div ? ST_DIV : ST_EXEC;
			ST_DIV:  if (stat.div_done) state_d = ST_EXEC;
			ST_EXEC: state_d = ST_DONE;
			ST_DONE: if (stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = (state_q == ST_IDLE);
		cmd.latch     = (state_q == ST_IDLE) && req_valid;
		cmd.mem_rd    = (state_q == ST_READ);
		cmd.div_start = (state_q == ST_READ) && stat.is_div;
		cmd.commit    = (state_q == ST_EXEC);
		cmd.out_load  = (state_q == ST_DONE) && stat.out_free;
	end

	a_latch_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch |=> state_q == ST_READ) else $error("latch not followed by read");
	a_commit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> state_q == ST_DONE) else $error("commit not followed by done");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !stat.div_done) |=> state_q == ST_DIV)
		else $error("left divide wait early");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE) else $error("result load not closing request");

endmodule

// File: hw/rtl/svie_dp.sv
module svie_dp
	import svie_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                cfg_we,
	input  logic [PC_W-1:0]     cfg_data,
	input  logic                in_command,
	input  logic [S_DATA_W-1:0] in_data,
	input  logic                div_done,
	input  logic [WORD_W-1:0]   div_quot,
	input  logic [WORD_W-1:0]   div_rem,
	output logic [WORD_W-1:0]   div_a,
	output logic [WORD_W-1:0]   div_b,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [M_DATA_W-1:0] out_data
);

	localparam int AW = $clog2(MEM_WORDS);

	logic              command_q;
	op_t               op_q;
	logic [WORD_W-1:0] opa_q, opb_q, rv_q, md_q;
	logic [PC_W-1:0]   pc_q, ma_q;

	logic [WORD_W-1:0] rf_q [NUM_REGS];
	logic [WORD_W-1:0] mem_q [MEM_WORDS];
	logic [WORD_W-1:0] a_s1, b_s1, mrd_s1;
	logic [AW-1:0]     sp_q;
	logic [1:0]        flags_q;

	logic [PC_W-1:0]   npc_q;
	logic              halt_q, wv_q, derr_q;
	logic [WORD_W-1:0] wval_q;
	logic              out_valid_q;
	logic [56:0]       out_q;

	logic [RIDX_W-1:0] ra, rb;
	logic [WORD_W-1:0] sum_a, sum_b;
	logic [AW-1:0]     addr_a, addr_b, sp_dec, sp_inc, rd_addr;
	logic [WORD_W-1:0] prod;

	logic              rf_we, mem_we, setf, sp_dn, sp_up, halt_d, wv_d, derr_d;
	logic [WORD_W-1:0] rf_wd, mem_wd, res, wval_d;
	logic [AW-1:0]     mem_wa;
	logic [PC_W-1:0]   npc_d;
	logic              is_exec;

	assign ra     = opa_q[RIDX_W-1:0];
	assign rb     = opb_q[RIDX_W-1:0];
	assign sum_a  = {{(WORD_W-PC_W){1'b0}}, pc_q} + opa_q;
	assign sum_b  = {{(WORD_W-PC_W){1'b0}}, pc_q} + opb_q;
	assign addr_a = sum_a[AW-1:0];
	assign addr_b = sum_b[AW-1:0];
	assign sp_dec = sp_q - 1'b1;
	assign sp_inc = sp_q + 1'b1;
	assign rd_addr = (op_q == OP_POP || op_q == OP_RET) ? sp_q : addr_b;
	assign prod   = a_s1 * b_s1;
	assign is_exec = (command_q == CMD_EXEC);

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			command_q <= in_command;
			op_q      <= op_t'(in_data[4:0]);
			opa_q     <= in_data[36:5];
			opb_q     <= in_data[68:37];
			pc_q      <= in_data[78:69];
			rv_q      <= in_data[110:79];
			ma_q      <= in_data[120:111];
			md_q      <= in_data[152:121];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			a_s1   <= rf_q[ra];
			b_s1   <= rf_q[rb];
			mrd_s1 <= mem_q[rd_addr];
		end
		if (mem_we) mem_q[mem_wa] <= mem_wd;
	end

	always_comb begin
		rf_we  = 1'b0;
		rf_wd  = '0;
		mem_we = 1'b0;
		mem_wa = addr_b;
		mem_wd = a_s1;
		setf   = 1'b0;
		res    = '0;
		sp_dn  = 1'b0;
		sp_up  = 1'b0;
		halt_d = 1'b0;
		wv_d   = 1'b0;
		wval_d = '0;
		derr_d = 1'b0;
		npc_d  = PC_W'(AW'(pc_q));
		if (!is_exec) begin
			mem_we = 1'b1;
			mem_wa = AW'(ma_q);
			mem_wd = md_q;
		end else begin
			case (op_q)
				OP_HALT:  halt_d = 1'b1;
				OP_LOAD: begin rf_we = 1'b1; rf_wd = mrd_s1; end
				OP_STORE: mem_we = 1'b1;
				OP_READ: begin rf_we = 1'b1; rf_wd = rv_q; end
				OP_WRITE: begin wv_d = 1'b1; wval_d = a_s1; end
				OP_COPY: begin rf_we = 1'b1; rf_wd = b_s1; end
				OP_PUSH: begin mem_we = 1'b1; mem_wa = sp_dec; sp_dn = 1'b1; end
				OP_POP: begin rf_we = 1'b1; rf_wd = mrd_s1; sp_up = 1'b1; end
				OP_JUMP:  npc_d = PC_W'(addr_a);
				OP_JZ:  if (flags_q[1])  npc_d = PC_W'(addr_a);
				OP_JNZ: if (!flags_q[1]) npc_d = PC_W'(addr_a);
				OP_JN:  if (flags_q[0])  npc_d = PC_W'(addr_a);
				OP_JNN: if (!flags_q[0]) npc_d = PC_W'(addr_a);
				OP_CALL: begin
					mem_we = 1'b1;
					mem_wa = sp_dec;
					mem_wd = {{(WORD_W-PC_W){1'b0}}, pc_q};
					sp_dn  = 1'b1;
					npc_d  = PC_W'(addr_a);
				end
				OP_RET: begin npc_d = PC_W'(mrd_s1[AW-1:0]); sp_up = 1'b1; end
				OP_AND: begin rf_we = 1'b1; rf_wd = a_s1 & b_s1; end
				OP_OR:  begin rf_we = 1'b1; rf_wd = a_s1 | b_s1; end
				OP_NOT: begin rf_we = 1'b1; rf_wd = ~a_s1; end
				OP_XOR: begin rf_we = 1'b1; rf_wd = a_s1 ^ b_s1; end
				OP_ADD: begin rf_we = 1'b1; rf_wd = a_s1 + b_s1; end
				OP_SUB: begin rf_we = 1'b1; rf_wd = a_s1 - b_s1; end
				OP_MUL: begin rf_we = 1'b1; rf_wd = prod; end
				OP_DIV, OP_MOD: begin
					if (b_s1 == '0) begin
						derr_d = 1'b1;
					end else begin
						rf_we = 1'b1;
						rf_wd = (op_q == OP_DIV) ? div_quot : div_rem;
					end
				end
				OP_CMP: begin setf = 1'b1; res = a_s1 - b_s1; end
				OP_TST: begin setf = 1'b1; res = a_s1 & b_s1; end
				default: ;
			endcase
			if (rf_we && op_q inside {[OP_COPY:OP_COPY], [OP_AND:OP_MOD]}) begin
				setf = 1'b1;
				res  = rf_wd;
			end
		end
		mem_we = mem_we && cmd.commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
			sp_q        <= '0;
			flags_q     <= FLAG_POS;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				if (rf_we) rf_q[ra] <= rf_wd;
				if (setf) flags_q <= flags_of(res);
			end
			if (cfg_we) sp_q <= AW'(cfg_data);
			else if (cmd.commit && sp_dn) sp_q <= sp_dec;
			else if (cmd.commit && sp_up) sp_q <= sp_inc;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			npc_q  <= npc_d;
			halt_q <= halt_d;
			wv_q   <= wv_d;
			wval_q <= wval_d;
			derr_q <= derr_d;
		end
		if (cmd.out_load)
			out_q <= {PC_W'(sp_q), derr_q, flags_q, wval_q, wv_q, halt_q, npc_q};
	end

	assign stat.is_div   = is_exec && (op_q == OP_DIV || op_q == OP_MOD);
	assign stat.div_done = div_done;
	assign stat.out_free = !out_valid_q || out_ready;
	assign div_a         = rf_q[ra];
	assign div_b         = rf_q[rb];
	assign out_valid     = out_valid_q;
	assign out_data      = {{(M_DATA_W-57){1'b0}}, out_q};

endmodule

// File: hw/rtl/small_vm_instruction_execute.sv
// channel   dir  handshake                  payload
// s         in   s_tvalid / s_tready        tdata: instruction or preload, tuser: command
// m         out  m_tvalid / m_tready        tdata: result of one request
// cfg       in   cfg_we                     stack_start, copied into the stack pointer
//
// A request goes through latch, read, execute and load result; DIV and MOD also wait
// in the bit-serial divider between read and execute, one quotient bit a cycle.
// arst_n clears registers, stack pointer, flags and the sequencer; memory is not cleared.
// A result waiting on m_tready holds the sequencer in its last step; a new request
// is still taken while that result sits in the output register.
module small_vm_instruction_execute
	import svie_pkg::*;
#(
	parameter int MEM_WORDS = MEM_WORDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// opcode, operand_a, operand_b, pc, read_value, mem_address, mem_data
	input  logic [S_DATA_W-1:0] s_tdata,
	// command
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// new_pc, halted, write_valid, write_value, flag_bits, div_error, stack_level
	output logic [M_DATA_W-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [PC_W-1:0]     cfg_data
);

	cmd_t              cmd;
	stat_t             stat;
	logic              div_done;
	logic [WORD_W-1:0] div_quot, div_rem, div_a, div_b;

	svie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.stat      (stat),
		.req_ready (s_tready),
		.cmd       (cmd)
	);

	svie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	svie_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_command (s_tuser),
		.in_data    (s_tdata),
		.div_done   (div_done),
		.div_quot   (div_quot),
		.div_rem    (div_rem),
		.div_a      (div_a),
		.div_b      (div_b),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_data   (m_tdata)
	);

endmodule
